// ----- hw/rtl/hec_pkg.sv -----
package hec_pkg;

  // grid and polynomial size
  localparam int ETA_POINTS = 8;
  localparam int POLY_TERMS = 4;
  localparam int LANES      = 2;

  // port field widths
  localparam int MOM_W    = 16;
  localparam int ETA_W    = 16;
  localparam int ENERGY_W = 24;

  // index widths
  localparam int ROW_W  = $clog2(ETA_POINTS);
  localparam int TERM_W = $clog2(POLY_TERMS);

  // clamped inputs
  localparam logic [MOM_W-1:0] MOM_MAX = MOM_W'(40960);
  localparam int ABS_W = 14;
  localparam logic [ABS_W-1:0] ETA_MAX = ABS_W'(10977);

  // eta weight: dx * recip (q30) rounded to nearest, q1.16
  localparam int DX_W      = 11;
  localparam int RECIP_W   = 20;
  localparam int WPROD_W   = DX_W + RECIP_W;
  localparam int WGT_SHIFT = 14;
  localparam int WGT_FRAC  = 16;
  localparam int WGT_W     = WGT_FRAC + 1;
  localparam logic [WPROD_W-1:0] WGT_HALF = WPROD_W'(1) << (WGT_SHIFT - 1);
  localparam logic [WGT_W-1:0]   WGT_ONE  = WGT_W'(1) << WGT_FRAC;

  // horner accumulator, q40 coefficients, product split in two halves
  localparam int ACC_W    = 48;
  localparam int SPLIT    = ACC_W / 2;
  localparam int MOM_FRAC = 10;
  localparam int PP_HI_W  = ACC_W - SPLIT + MOM_W + 1;
  localparam int PP_LO_W  = SPLIT + MOM_W;
  localparam int PROD_W   = ACC_W + MOM_W + 1;
  localparam logic signed [PROD_W-1:0] HORNER_HALF = PROD_W'(1) << (MOM_FRAC - 1);

  // row energy q8.16 and interpolation
  localparam int ROW_SHIFT = 24;
  localparam int ROW_E_W   = ACC_W - ROW_SHIFT;
  localparam int DIFF_W    = ROW_E_W + 1;
  localparam int IPROD_W   = DIFF_W + WGT_W + 1;
  localparam int SUM_W     = IPROD_W - WGT_FRAC + 1;
  localparam logic signed [ACC_W-1:0]   E_HALF      = ACC_W'(1) << (ROW_SHIFT - 1);
  localparam logic signed [IPROD_W-1:0] INTERP_HALF = IPROD_W'(1) << (WGT_FRAC - 1);
  localparam logic signed [SUM_W-1:0]   SAT_HI =
    SUM_W'((64'sd1 <<< (ENERGY_W - 1)) - 64'sd1);
  localparam logic signed [SUM_W-1:0]   SAT_LO = ~SAT_HI;

  // pipeline depth: front, two stages per horner step, back
  localparam int FRONT_STAGES = 3;
  localparam int BACK_STAGES  = 3;
  localparam int PIPE_DEPTH   = FRONT_STAGES + 2 * (POLY_TERMS - 1) + BACK_STAGES;

  // eta grid in q1.14
  localparam logic [ABS_W-1:0] ETA_GRID [ETA_POINTS] = '{
    ABS_W'(0), ABS_W'(1638), ABS_W'(3277), ABS_W'(4915),
    ABS_W'(6554), ABS_W'(8192), ABS_W'(9830), ABS_W'(10977)
  };

  // reciprocal grid spacings in q30
  localparam longint Q30 = 64'sd1073741824;
  localparam logic [RECIP_W-1:0] ETA_RECIP [ETA_POINTS-1] = '{
    RECIP_W'((Q30 + 64'sd1638 / 64'sd2) / 64'sd1638),
    RECIP_W'((Q30 + 64'sd1639 / 64'sd2) / 64'sd1639),
    RECIP_W'((Q30 + 64'sd1638 / 64'sd2) / 64'sd1638),
    RECIP_W'((Q30 + 64'sd1639 / 64'sd2) / 64'sd1639),
    RECIP_W'((Q30 + 64'sd1638 / 64'sd2) / 64'sd1638),
    RECIP_W'((Q30 + 64'sd1638 / 64'sd2) / 64'sd1638),
    RECIP_W'((Q30 + 64'sd1147 / 64'sd2) / 64'sd1147)
  };

  // coefficient rom, q40, 64-bit two's complement arithmetic as given
  localparam longint Q41 = 64'sd2199023255552;
  localparam longint D7  = 64'sd10000000;
  localparam longint D8  = 64'sd100000000;
  localparam longint D9  = 64'sd1000000000;
  localparam longint D10 = 64'sd10000000000;
  localparam longint ONE = 64'sd1;
  localparam longint TWO = 64'sd2;

  localparam logic signed [ACC_W-1:0] COEF_ROM [ETA_POINTS][POLY_TERMS] = '{
    '{ ACC_W'(((64'sd1305705 * Q41) / D7 + ONE) / TWO),
       ACC_W'(((64'sd3725653 * Q41) / D7 + ONE) / TWO),
       ACC_W'(-(((64'sd1219962 * Q41) / D8 + ONE) / TWO)),
       ACC_W'(((64'sd1806235 * Q41) / D10 + ONE) / TWO) },
    '{ ACC_W'(((64'sd1296153 * Q41) / D7 + ONE) / TWO),
       ACC_W'(((64'sd3827408 * Q41) / D7 + ONE) / TWO),
       ACC_W'(-(((64'sd1238640 * Q41) / D8 + ONE) / TWO)),
       ACC_W'(((64'sd1822804 * Q41) / D10 + ONE) / TWO) },
    '{ ACC_W'(((64'sd1337690 * Q41) / D7 + ONE) / TWO),
       ACC_W'(((64'sd3797454 * Q41) / D7 + ONE) / TWO),
       ACC_W'(-(((64'sd1245227 * Q41) / D8 + ONE) / TWO)),
       ACC_W'(((64'sd1848243 * Q41) / D10 + ONE) / TWO) },
    '{ ACC_W'(((64'sd1395796 * Q41) / D7 + ONE) / TWO),
       ACC_W'(((64'sd3623994 * Q41) / D7 + ONE) / TWO),
       ACC_W'(-(((64'sd9196803 * Q41) / D9 + ONE) / TWO)),
       ACC_W'(((64'sd1243278 * Q41) / D10 + ONE) / TWO) },
    '{ ACC_W'(((64'sd1457184 * Q41) / D7 + ONE) / TWO),
       ACC_W'(((64'sd3753655 * Q41) / D7 + ONE) / TWO),
       ACC_W'(-(((64'sd1035324 * Q41) / D8 + ONE) / TWO)),
       ACC_W'(((64'sd1473447 * Q41) / D10 + ONE) / TWO) },
    '{ ACC_W'(((64'sd1329164 * Q41) / D7 + ONE) / TWO),
       ACC_W'(((64'sd4219044 * Q41) / D7 + ONE) / TWO),
       ACC_W'(-(((64'sd1310515 * Q41) / D8 + ONE) / TWO)),
       ACC_W'(((64'sd1948883 * Q41) / D10 + ONE) / TWO) },
    '{ ACC_W'(((64'sd8136581 * Q41) / D8 + ONE) / TWO),
       ACC_W'(((64'sd4646087 * Q41) / D7 + ONE) / TWO),
       ACC_W'(-(((64'sd1531917 * Q41) / D8 + ONE) / TWO)),
       ACC_W'(((64'sd2274749 * Q41) / D10 + ONE) / TWO) },
    '{ ACC_W'(((64'sd1119836 * Q41) / D7 + ONE) / TWO),
       ACC_W'(((64'sd4262497 * Q41) / D7 + ONE) / TWO),
       ACC_W'(-(((64'sd1160125 * Q41) / D8 + ONE) / TWO)),
       ACC_W'(((64'sd1628738 * Q41) / D10 + ONE) / TWO) }
  };

  // item travelling through the horner steps, lane 0 lower row, lane 1 upper row
  typedef struct packed {
    logic [MOM_W-1:0]             mom;
    logic [ROW_W-1:0]             row;
    logic [WGT_W-1:0]             wgt;
    logic [LANES-1:0][ACC_W-1:0]  acc;
  } hec_item_t;

endpackage

// ----- hw/rtl/hec_front.sv -----
module hec_front import hec_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    valid_i,
  output logic                    ready_o,
  input  logic [MOM_W-1:0]        momentum_i,
  input  logic signed [ETA_W-1:0] pseudorapidity_i,
  output logic                    valid_o,
  input  logic                    ready_i,
  output hec_item_t               item_o
);

  logic s0_ready, s1_ready, s2_ready;
  logic s0_valid_q, s1_valid_q, s2_valid_q;

  logic [MOM_W-1:0]     s0_mom_d, s0_mom_q, s1_mom_q;
  logic [ETA_W:0]       eta_mag;
  logic [ABS_W-1:0]     s0_abs_d, s0_abs_q;
  logic [ROW_W-1:0]     s0_row_d, s0_row_q, s1_row_q, row_up;
  logic [DX_W-1:0]      dx;
  logic [WPROD_W-1:0]   s1_wprod_d, s1_wprod_q;
  logic [WPROD_W:0]     wsum;
  logic [WPROD_W-WGT_SHIFT:0] wraw;
  hec_item_t            s2_item_d, s2_item_q;

  // stage enables, a stage moves when empty or when the next one moves
  assign s2_ready = !s2_valid_q || ready_i;
  assign s1_ready = !s1_valid_q || s2_ready;
  assign s0_ready = !s0_valid_q || s1_ready;
  assign ready_o  = s0_ready;

  // stage 0: clamp momentum and |eta|, pick the grid row
  always_comb begin
    s0_mom_d = (momentum_i > MOM_MAX) ? MOM_MAX : momentum_i;
    eta_mag  = pseudorapidity_i[ETA_W-1] ? ({1'b0, ~pseudorapidity_i} + (ETA_W+1)'(1))
                                         : {1'b0, pseudorapidity_i};
    s0_abs_d = (eta_mag > (ETA_W+1)'(ETA_MAX)) ? ETA_MAX : eta_mag[ABS_W-1:0];
    s0_row_d = '0;
    for (int i = 1; i <= ETA_POINTS - 2; i++) begin
      if (s0_abs_d >= ETA_GRID[i]) begin
        s0_row_d = ROW_W'(i);
      end
    end
  end

  // stage 1: offset inside the interval times reciprocal spacing
  always_comb begin
    dx         = DX_W'(s0_abs_q - ETA_GRID[s0_row_q]);
    s1_wprod_d = WPROD_W'(dx) * WPROD_W'(ETA_RECIP[s0_row_q]);
  end

  // stage 2: round and cap the weight, seed both accumulators
  always_comb begin
    row_up           = s1_row_q + ROW_W'(1);
    wsum             = (WPROD_W+1)'(s1_wprod_q) + (WPROD_W+1)'(WGT_HALF);
    wraw             = wsum[WPROD_W:WGT_SHIFT];
    s2_item_d.mom    = s1_mom_q;
    s2_item_d.row    = s1_row_q;
    s2_item_d.wgt    = (wraw > (WPROD_W+1-WGT_SHIFT)'(WGT_ONE)) ? WGT_ONE
                                                                 : wraw[WGT_W-1:0];
    s2_item_d.acc[0] = COEF_ROM[s1_row_q][POLY_TERMS-1];
    s2_item_d.acc[1] = COEF_ROM[row_up][POLY_TERMS-1];
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (s0_ready) s0_valid_q <= valid_i;
      if (s1_ready) s1_valid_q <= s0_valid_q;
      if (s2_ready) s2_valid_q <= s1_valid_q;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (valid_i && s0_ready) begin
      s0_mom_q <= s0_mom_d;
      s0_abs_q <= s0_abs_d;
      s0_row_q <= s0_row_d;
    end
    if (s0_valid_q && s1_ready) begin
      s1_mom_q   <= s0_mom_q;
      s1_row_q   <= s0_row_q;
      s1_wprod_q <= s1_wprod_d;
    end
    if (s1_valid_q && s2_ready) begin
      s2_item_q <= s2_item_d;
    end
  end

  assign valid_o = s2_valid_q;
  assign item_o  = s2_item_q;

endmodule

// ----- hw/rtl/hec_horner_step.sv -----
module hec_horner_step import hec_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [TERM_W-1:0] term_i,
  input  logic              valid_i,
  output logic              ready_o,
  input  hec_item_t         item_i,
  output logic              valid_o,
  input  logic              ready_i,
  output hec_item_t         item_o
);

  logic mul_ready, add_ready;
  logic mul_valid_q, add_valid_q;

  logic [MOM_W-1:0]          mul_mom_q;
  logic [ROW_W-1:0]          mul_row_q;
  logic [WGT_W-1:0]          mul_wgt_q;
  logic signed [PP_HI_W-1:0] pp_hi_d [LANES];
  logic signed [PP_HI_W-1:0] pp_hi_q [LANES];
  logic [PP_LO_W-1:0]        pp_lo_d [LANES];
  logic [PP_LO_W-1:0]        pp_lo_q [LANES];
  logic signed [PROD_W-1:0]  prod_full [LANES];
  logic signed [PROD_W-1:0]  prod_rnd [LANES];
  logic [ROW_W-1:0]          coef_row [LANES];
  hec_item_t                 add_item_d, add_item_q;

  assign add_ready = !add_valid_q || ready_i;
  assign mul_ready = !mul_valid_q || add_ready;
  assign ready_o   = mul_ready;

  // multiply stage: acc * p as signed upper half and unsigned lower half
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      pp_hi_d[l] = PP_HI_W'($signed(item_i.acc[l][ACC_W-1:SPLIT]))
                 * PP_HI_W'($signed({1'b0, item_i.mom}));
      pp_lo_d[l] = PP_LO_W'(item_i.acc[l][SPLIT-1:0]) * PP_LO_W'(item_i.mom);
    end
  end

  // add stage: join halves, round off the momentum fraction, add coefficient
  always_comb begin
    add_item_d.mom = mul_mom_q;
    add_item_d.row = mul_row_q;
    add_item_d.wgt = mul_wgt_q;
    for (int l = 0; l < LANES; l++) begin
      prod_full[l] = (PROD_W'(pp_hi_q[l]) <<< SPLIT) + $signed(PROD_W'(pp_lo_q[l]));
      prod_rnd[l]  = (prod_full[l] + HORNER_HALF) >>> MOM_FRAC;
      coef_row[l]  = mul_row_q + ROW_W'(l);
      add_item_d.acc[l] = ACC_W'(prod_rnd[l]) + COEF_ROM[coef_row[l]][term_i];
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_valid_q <= 1'b0;
      add_valid_q <= 1'b0;
    end else begin
      if (mul_ready) mul_valid_q <= valid_i;
      if (add_ready) add_valid_q <= mul_valid_q;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (valid_i && mul_ready) begin
      mul_mom_q <= item_i.mom;
      mul_row_q <= item_i.row;
      mul_wgt_q <= item_i.wgt;
      for (int l = 0; l < LANES; l++) begin
        pp_hi_q[l] <= pp_hi_d[l];
        pp_lo_q[l] <= pp_lo_d[l];
      end
    end
    if (mul_valid_q && add_ready) begin
      add_item_q <= add_item_d;
    end
  end

  assign valid_o = add_valid_q;
  assign item_o  = add_item_q;

endmodule

// ----- hw/rtl/hec_interp.sv -----
module hec_interp import hec_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  output logic                       ready_o,
  input  hec_item_t                  item_i,
  output logic                       valid_o,
  input  logic                       ready_i,
  output logic signed [ENERGY_W-1:0] energy_o
);

  logic rnd_ready, mul_ready, out_ready;
  logic rnd_valid_q, mul_valid_q, out_valid_q;

  logic signed [ACC_W-1:0]   acc_rnd [LANES];
  logic signed [ROW_E_W-1:0] e_d [LANES];
  logic signed [ROW_E_W-1:0] e_q [LANES];
  logic [WGT_W-1:0]          rnd_wgt_q;
  logic signed [DIFF_W-1:0]  diff;
  logic signed [IPROD_W-1:0] iprod_d, iprod_q;
  logic signed [ROW_E_W-1:0] base_q;
  logic signed [IPROD_W-1:0] iadj;
  logic signed [SUM_W-1:0]   esum;
  logic signed [ENERGY_W-1:0] energy_d, energy_q;

  assign out_ready = !out_valid_q || ready_i;
  assign mul_ready = !mul_valid_q || out_ready;
  assign rnd_ready = !rnd_valid_q || mul_ready;
  assign ready_o   = rnd_ready;

  // row energies rounded from q40 to q8.16
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      acc_rnd[l] = $signed(item_i.acc[l]) + E_HALF;
      e_d[l]     = acc_rnd[l][ACC_W-1:ROW_SHIFT];
    end
  end

  // difference of the two rows times the eta weight
  always_comb begin
    diff    = DIFF_W'(e_q[1]) - DIFF_W'(e_q[0]);
    iprod_d = IPROD_W'(diff) * IPROD_W'($signed({1'b0, rnd_wgt_q}));
  end

  // round, add the lower row, saturate
  always_comb begin
    iadj = (iprod_q + INTERP_HALF) >>> WGT_FRAC;
    esum = SUM_W'(iadj) + SUM_W'(base_q);
    if (esum > SAT_HI) begin
      energy_d = ENERGY_W'(SAT_HI);
    end else if (esum < SAT_LO) begin
      energy_d = ENERGY_W'(SAT_LO);
    end else begin
      energy_d = ENERGY_W'(esum);
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rnd_valid_q <= 1'b0;
      mul_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (rnd_ready) rnd_valid_q <= valid_i;
      if (mul_ready) mul_valid_q <= rnd_valid_q;
      if (out_ready) out_valid_q <= mul_valid_q;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (valid_i && rnd_ready) begin
      for (int l = 0; l < LANES; l++) begin
        e_q[l] <= e_d[l];
      end
      rnd_wgt_q <= item_i.wgt;
    end
    if (rnd_valid_q && mul_ready) begin
      iprod_q <= iprod_d;
      base_q  <= e_q[0];
    end
    if (mul_valid_q && out_ready) begin
      energy_q <= energy_d;
    end
  end

  assign valid_o  = out_valid_q;
  assign energy_o = energy_q;

endmodule

// ----- hw/rtl/hadron_energy_correction_interp.sv -----
// pipeline: from input transfer to result valid, 3 front stages,
//   2 stages per horner step (POLY_TERMS-1 steps) and 3 interpolation stages
// throughput: one track per cycle unless out_ready_i stalls; each horner step registers
//   acc * p as a 24 x 17 and a 24 x 16 bit partial product ahead of the add
// reset: clears only the valid bits of every stage, payload is not reset
module hadron_energy_correction_interp import hec_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [MOM_W-1:0]           momentum_i,
  input  logic signed [ETA_W-1:0]    pseudorapidity_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic signed [ENERGY_W-1:0] energy_o
);

  hec_item_t               chain_item [POLY_TERMS];
  logic [POLY_TERMS-1:0]   chain_valid;
  logic [POLY_TERMS-1:0]   chain_ready;

  // clamp, row select, weight
  hec_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .valid_i          (in_valid_i),
    .ready_o          (in_ready_o),
    .momentum_i       (momentum_i),
    .pseudorapidity_i (pseudorapidity_i),
    .valid_o          (chain_valid[0]),
    .ready_i          (chain_ready[0]),
    .item_o           (chain_item[0])
  );

  // horner steps, highest remaining term first
  for (genvar k = 0; k < POLY_TERMS - 1; k++) begin : g_step
    hec_horner_step u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .term_i  (TERM_W'(POLY_TERMS - 2 - k)),
      .valid_i (chain_valid[k]),
      .ready_o (chain_ready[k]),
      .item_i  (chain_item[k]),
      .valid_o (chain_valid[k+1]),
      .ready_i (chain_ready[k+1]),
      .item_o  (chain_item[k+1])
    );
  end

  // eta interpolation and output register
  hec_interp u_interp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (chain_valid[POLY_TERMS-1]),
    .ready_o  (chain_ready[POLY_TERMS-1]),
    .item_i   (chain_item[POLY_TERMS-1]),
    .valid_o  (out_valid_o),
    .ready_i  (out_ready_i),
    .energy_o (energy_o)
  );

endmodule

// ----- hw/rtl/hec_checker.sv -----
module hec_checker import hec_pkg::*; (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_o,
  input logic [MOM_W-1:0]           momentum_i,
  input logic signed [ETA_W-1:0]    pseudorapidity_i,
  input logic                       out_valid_o,
  input logic                       out_ready_i,
  input logic signed [ENERGY_W-1:0] energy_o
);

  localparam int CNT_W = $clog2(PIPE_DEPTH + 1);

  logic             in_xfer, out_xfer;
  logic [CNT_W-1:0] cnt_d, cnt_q;

  // items in flight, seen from the ports
  assign in_xfer  = in_valid_i && in_ready_o;
  assign out_xfer = out_valid_o && out_ready_i;

  always_comb begin
    cnt_d = cnt_q + CNT_W'(in_xfer) - CNT_W'(out_xfer);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // a waiting input holds its payload
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(momentum_i)
      && $stable(pseudorapidity_i))
    else $error("waiting input changed");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(energy_o))
    else $error("stalled result changed");

  // no result without a transfer in flight
  a_no_extra: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> cnt_q != '0)
    else $error("result without a pending input");

  // never more items in flight than pipeline stages
  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(PIPE_DEPTH))
    else $error("more items in flight than stages");

  // an empty pipeline takes input
  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == '0 |-> in_ready_o)
    else $error("empty pipeline not ready");

endmodule

bind hadron_energy_correction_interp hec_checker u_hec_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_ready_o       (in_ready_o),
  .momentum_i       (momentum_i),
  .pseudorapidity_i (pseudorapidity_i),
  .out_valid_o      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .energy_o         (energy_o)
);
